// File: src/mcof_pkg.sv
// Shared constants, codes and corner arithmetic for the mesh corner finder.
package mcof_pkg;

    localparam int MAX_CORNERS = 3072;
    localparam int MAX_VERTS   = 1024;

    localparam int CW  = 12;   // corner index width
    localparam int VW  = 10;   // vertex index width
    localparam int SW  = 13;   // ring step counter width
    localparam int VMW = 1 + 2 * CW;  // vertex entry: valid, first, last

    typedef logic [CW-1:0] t_corner;
    typedef logic [VW-1:0] t_vert;

    localparam logic [2:0] MODE_LOAD   = 3'd0;
    localparam logic [2:0] MODE_OPP    = 3'd1;
    localparam logic [2:0] MODE_NEXT   = 3'd2;
    localparam logic [2:0] MODE_BORDER = 3'd3;
    localparam logic [2:0] MODE_CLEAR  = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_NONE = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_BAD  = 2'd3;

    // c mod 3 through a reciprocal multiply (exact for 12-bit c)
    function automatic logic [1:0] f_mod3(input t_corner c);
        logic [23:0] p;
        t_corner     q;
        t_corner     r;
        p = 24'(c) * 24'd2731;
        q = CW'(p >> 13);
        r = c - CW'(q * 12'd3);
        return r[1:0];
    endfunction

    // preceding corner within the face
    function automatic t_corner f_prev(input t_corner c);
        return (f_mod3(c) == 2'd0) ? c + 12'd2 : c - 12'd1;
    endfunction

    // following corner within the face
    function automatic t_corner f_next(input t_corner c);
        return (f_mod3(c) == 2'd2) ? c - 12'd2 : c + 12'd1;
    endfunction

endpackage

// File: src/mcof_ram.sv
// Generic single-port RAM with registered read.
module mcof_ram #(
    parameter int P_WIDTH = 8,
    parameter int P_DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic [$clog2(P_DEPTH)-1:0] i_addr,
    input  logic                       i_we,
    input  logic [P_WIDTH-1:0]         i_wdata,
    output logic [P_WIDTH-1:0]         o_rdata
);

    logic [P_WIDTH-1:0] r_mem [P_DEPTH];
    logic [P_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/mesh_corner_opposite_finder.sv
// Top level: corner table of a triangle mesh with opposite-corner queries.
//
// Input channel (i_valid / o_stall) carries one item: mode, vertex, corner.
// Output channel (o_valid / i_stall) returns one result item per input item.
// Loads write the corner's vertex and splice it into its vertex ring.
// Opposite and next-around-vertex queries walk one ring through a shared
// sequencer: setup states FO_INIT, FO_TC, FO_FC, then FO_A to FO_D per member,
// since every member needs three reads of the single corner-vertex RAM port,
// and a return state FO_RET. A load runs LD_RD, LD_WR and LD_LINK, an error
// is answered from idle, a border test one full opposite walk per vertex ring member.
// Clear sweeps the 1024 vertex entries, one per cycle, then answers.
// After reset the same sweep runs with o_stall high; no result
// is produced for it.
// One item is in work at a time; o_stall stays high until the result has
// been taken. A stalled result holds its value until i_stall drops.
module mesh_corner_opposite_finder (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [2:0]            i_mode,
    input  logic [mcof_pkg::VW-1:0] i_vertex_index,
    input  logic [mcof_pkg::CW-1:0] i_corner_index,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [1:0]            o_status,
    output logic [mcof_pkg::CW-1:0] o_result_corner,
    output logic                  o_is_border
);
    import mcof_pkg::*;

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_CLR     = 5'd1;
    localparam logic [4:0] S_LD_RD   = 5'd2;
    localparam logic [4:0] S_LD_WR   = 5'd3;
    localparam logic [4:0] S_LD_LINK = 5'd4;
    localparam logic [4:0] S_FO_INIT = 5'd5;
    localparam logic [4:0] S_FO_TC   = 5'd6;
    localparam logic [4:0] S_FO_FC   = 5'd7;
    localparam logic [4:0] S_FO_A    = 5'd8;
    localparam logic [4:0] S_FO_B    = 5'd9;
    localparam logic [4:0] S_FO_C    = 5'd10;
    localparam logic [4:0] S_FO_D    = 5'd11;
    localparam logic [4:0] S_FO_RET  = 5'd12;
    localparam logic [4:0] S_BD_RD   = 5'd13;
    localparam logic [4:0] S_BD_V    = 5'd14;
    localparam logic [4:0] S_BD_N    = 5'd15;

    // control state
    logic [4:0]    r_state, n_state;
    logic          r_init, n_init;
    logic          r_ovld, n_ovld;
    t_corner       r_count, n_count;
    t_corner       r_lim, n_lim;
    logic [1:0]    r_cmod, n_cmod;
    logic [VW-1:0] r_clr, n_clr;

    // payload / working registers
    logic [2:0]    r_mode, n_mode;
    t_vert         r_v, n_v;
    logic [1:0]    r_ost, n_ost;
    t_corner       r_ores, n_ores;
    logic          r_obrd, n_obrd;
    t_corner       r_tmp, n_tmp;
    t_corner       r_fc, n_fc;       // corner whose opposite is sought
    t_vert         r_tc, n_tc;       // head vertex of that corner
    t_vert         r_fcv, n_fcv;     // tail vertex of that corner
    t_corner       r_cir, n_cir;
    t_corner       r_cand, n_cand;
    t_vert         r_tcand, n_tcand;
    t_vert         r_vcir, n_vcir;
    t_corner       r_rnx, n_rnx;
    logic          r_found, n_found;
    t_corner       r_fres, n_fres;
    logic [SW-1:0] r_steps, n_steps;
    logic [1:0]    r_fost, n_fost;
    t_corner       r_bstart, n_bstart;
    t_corner       r_bcir, n_bcir;
    logic [SW-1:0] r_bsteps, n_bsteps;

    // RAM ports
    t_corner        cv_addr, rn_addr, rn_wd, rn_rd;
    t_vert          cv_wd, cv_rd, vm_addr;
    logic           cv_we, rn_we, vm_we;
    logic [VMW-1:0] vm_wd, vm_rd;

    logic          acc;
    logic          match;
    logic [SW-1:0] steps_inc, bsteps_inc;

    mcof_ram #(.P_WIDTH(VW), .P_DEPTH(MAX_CORNERS)) u_corner_vertex (
        .i_clk(i_clk), .i_addr(cv_addr), .i_we(cv_we), .i_wdata(cv_wd), .o_rdata(cv_rd)
    );

    mcof_ram #(.P_WIDTH(CW), .P_DEPTH(MAX_CORNERS)) u_ring_next (
        .i_clk(i_clk), .i_addr(rn_addr), .i_we(rn_we), .i_wdata(rn_wd), .o_rdata(rn_rd)
    );

    mcof_ram #(.P_WIDTH(VMW), .P_DEPTH(MAX_VERTS)) u_vertex (
        .i_clk(i_clk), .i_addr(vm_addr), .i_we(vm_we), .i_wdata(vm_wd), .o_rdata(vm_rd)
    );

    assign o_stall = (r_state != S_IDLE) || r_ovld;
    assign acc     = i_valid && !o_stall;
    assign o_valid = r_ovld;
    assign o_status        = r_ost;
    assign o_result_corner = r_ores;
    assign o_is_border     = r_obrd;

    assign match      = (r_tcand == r_tc) && (r_vcir == r_fcv);
    assign steps_inc  = r_steps + 13'd1;
    assign bsteps_inc = r_bsteps + 13'd1;

    // sequencer
    always_comb begin
        n_state = r_state;  n_init = r_init;   n_ovld = r_ovld;
        n_count = r_count;  n_lim = r_lim;     n_cmod = r_cmod;   n_clr = r_clr;
        n_mode = r_mode;    n_v = r_v;         n_ost = r_ost;     n_ores = r_ores;
        n_obrd = r_obrd;    n_tmp = r_tmp;     n_fc = r_fc;       n_tc = r_tc;
        n_fcv = r_fcv;      n_cir = r_cir;     n_cand = r_cand;   n_tcand = r_tcand;
        n_vcir = r_vcir;    n_rnx = r_rnx;     n_found = r_found; n_fres = r_fres;
        n_steps = r_steps;  n_fost = r_fost;   n_bstart = r_bstart;
        n_bcir = r_bcir;    n_bsteps = r_bsteps;
        cv_addr = r_cir;    cv_we = 1'b0;      cv_wd = r_v;
        rn_addr = r_cir;    rn_we = 1'b0;      rn_wd = r_count;
        vm_addr = r_v;      vm_we = 1'b0;      vm_wd = '0;

        if (r_ovld && !i_stall) begin
            n_ovld = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_mode = i_mode;
                    n_v    = i_vertex_index;
                    n_ost  = ST_OK;
                    n_ores = '0;
                    n_obrd = 1'b0;
                    case (i_mode)
                        MODE_LOAD: begin
                            if (r_count >= CW'(MAX_CORNERS)) begin
                                n_ost  = ST_FULL;
                                n_ovld = 1'b1;
                            end else begin
                                n_state = S_LD_RD;
                            end
                        end
                        MODE_OPP, MODE_NEXT: begin
                            if (i_corner_index >= r_lim) begin
                                n_ost  = ST_BAD;
                                n_ovld = 1'b1;
                            end else begin
                                n_fc = (i_mode == MODE_NEXT) ? f_prev(i_corner_index)
                                                             : i_corner_index;
                                n_state = S_FO_INIT;
                            end
                        end
                        MODE_BORDER: n_state = S_BD_RD;
                        MODE_CLEAR: begin
                            n_clr   = '0;
                            n_state = S_CLR;
                        end
                        default: begin
                            n_ost  = ST_BAD;
                            n_ovld = 1'b1;
                        end
                    endcase
                end
            end

            // sweep vertex entries invalid
            S_CLR: begin
                vm_addr = r_clr;
                vm_we   = 1'b1;
                n_clr   = r_clr + 10'd1;
                if (r_clr == VW'(MAX_VERTS - 1)) begin
                    n_count = '0;
                    n_lim   = '0;
                    n_cmod  = 2'd0;
                    n_init  = 1'b0;
                    n_ovld  = !r_init;
                    n_state = S_IDLE;
                end
            end

            // load: store vertex, fetch its ring ends
            S_LD_RD: begin
                cv_addr = r_count;
                cv_we   = 1'b1;
                n_state = S_LD_WR;
            end

            S_LD_WR: begin
                vm_we   = 1'b1;
                vm_wd   = {1'b1, (vm_rd[VMW-1] ? vm_rd[2*CW-1:CW] : r_count), r_count};
                rn_addr = r_count;
                rn_we   = 1'b1;
                rn_wd   = vm_rd[VMW-1] ? vm_rd[CW-1:0] : r_count;
                n_tmp   = vm_rd[VMW-1] ? vm_rd[2*CW-1:CW] : r_count;
                n_state = S_LD_LINK;
            end

            // first corner of the ring now points at the new one
            S_LD_LINK: begin
                rn_addr = r_tmp;
                rn_we   = 1'b1;
                n_ores  = r_count;
                n_count = r_count + 12'd1;
                if (r_cmod == 2'd2) begin
                    n_cmod = 2'd0;
                    n_lim  = r_count + 12'd1;
                end else begin
                    n_cmod = r_cmod + 2'd1;
                end
                n_ovld  = 1'b1;
                n_state = S_IDLE;
            end

            // opposite walk: fetch head and tail vertices of r_fc
            S_FO_INIT: begin
                if (r_fc >= r_lim) begin
                    n_fost  = ST_BAD;
                    n_state = S_FO_RET;
                end else begin
                    cv_addr = f_next(r_fc);
                    n_state = S_FO_TC;
                end
            end

            S_FO_TC: begin
                n_tc    = cv_rd;
                cv_addr = r_fc;
                n_state = S_FO_FC;
            end

            S_FO_FC: begin
                n_fcv   = cv_rd;
                n_cir   = r_fc;
                n_found = 1'b0;
                n_steps = '0;
                n_state = S_FO_A;
            end

            // one ring member: candidate tail, ring link
            S_FO_A: begin
                if (r_cir >= r_lim) begin
                    n_fost  = ST_BAD;
                    n_state = S_FO_RET;
                end else begin
                    n_cand  = f_prev(r_cir);
                    cv_addr = f_prev(r_cir);
                    rn_addr = r_cir;
                    n_state = S_FO_B;
                end
            end

            S_FO_B: begin
                n_tcand = cv_rd;
                n_rnx   = rn_rd;
                cv_addr = r_cir;
                n_state = S_FO_C;
            end

            S_FO_C: begin
                n_vcir  = cv_rd;
                cv_addr = f_next(r_cir);
                n_state = S_FO_D;
            end

            // cv_rd holds the head vertex of the ring member
            S_FO_D: begin
                if (match && r_found) begin
                    n_fost  = ST_NONE;
                    n_state = S_FO_RET;
                end else if ((r_cir != r_fc) && (cv_rd == r_tc)) begin
                    n_fost  = ST_NONE;
                    n_state = S_FO_RET;
                end else begin
                    if (match) begin
                        n_found = 1'b1;
                        n_fres  = r_cand;
                    end
                    n_cir   = r_rnx;
                    n_steps = steps_inc;
                    if (steps_inc > SW'(MAX_CORNERS)) begin
                        n_fost  = ST_BAD;
                        n_state = S_FO_RET;
                    end else if (r_rnx == r_fc) begin
                        n_fost  = (match || r_found) ? ST_OK : ST_NONE;
                        n_state = S_FO_RET;
                    end else begin
                        n_state = S_FO_A;
                    end
                end
            end

            S_FO_RET: begin
                if (r_mode == MODE_BORDER) begin
                    if (r_fost == ST_BAD) begin
                        n_ost   = ST_BAD;
                        n_ovld  = 1'b1;
                        n_state = S_IDLE;
                    end else if (r_fost == ST_NONE) begin
                        n_obrd  = 1'b1;
                        n_ovld  = 1'b1;
                        n_state = S_IDLE;
                    end else if (bsteps_inc > SW'(MAX_CORNERS)) begin
                        n_ost   = ST_BAD;
                        n_ovld  = 1'b1;
                        n_state = S_IDLE;
                    end else if (r_bcir == r_bstart) begin
                        n_ovld  = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        rn_addr  = r_bcir;
                        n_bsteps = bsteps_inc;
                        n_state  = S_BD_N;
                    end
                end else begin
                    n_ost   = r_fost;
                    n_ores  = (r_fost == ST_OK) ? r_fres : '0;
                    n_ovld  = 1'b1;
                    n_state = S_IDLE;
                end
            end

            // border test: read vertex entry, step around its ring
            S_BD_RD: begin
                n_state = S_BD_V;
            end

            S_BD_V: begin
                if (!vm_rd[VMW-1]) begin
                    n_ovld  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_bstart = vm_rd[CW-1:0];
                    rn_addr  = vm_rd[CW-1:0];
                    n_bsteps = '0;
                    n_state  = S_BD_N;
                end
            end

            S_BD_N: begin
                n_bcir  = rn_rd;
                n_fc    = rn_rd;
                n_state = S_FO_INIT;
            end

            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_init  <= 1'b1;
            r_ovld  <= 1'b0;
            r_count <= '0;
            r_lim   <= '0;
            r_cmod  <= 2'd0;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_init  <= n_init;
            r_ovld  <= n_ovld;
            r_count <= n_count;
            r_lim   <= n_lim;
            r_cmod  <= n_cmod;
            r_clr   <= n_clr;
        end
    end

    // payload and working registers
    always_ff @(posedge i_clk) begin
        r_mode   <= n_mode;   r_v      <= n_v;      r_ost    <= n_ost;
        r_ores   <= n_ores;   r_obrd   <= n_obrd;   r_tmp    <= n_tmp;
        r_fc     <= n_fc;     r_tc     <= n_tc;     r_fcv    <= n_fcv;
        r_cir    <= n_cir;    r_cand   <= n_cand;   r_tcand  <= n_tcand;
        r_vcir   <= n_vcir;   r_rnx    <= n_rnx;    r_found  <= n_found;
        r_fres   <= n_fres;   r_steps  <= n_steps;  r_fost   <= n_fost;
        r_bstart <= n_bstart; r_bcir   <= n_bcir;   r_bsteps <= n_bsteps;
    end

endmodule
